// File: rtl/dmr_pkg.sv
package dmr_pkg;

    // Duty resolution of the bridge PWM; the drive limit never exceeds its ceiling.
    localparam int PWM_BITS  = 8;
    localparam int DUTY_CEIL = (1 << PWM_BITS) - 1;

    // Command codes carried by the cmd field.
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_SET  = 2'd1;
    localparam logic [1:0] CMD_STOP = 2'd2;

    // Bridge direction codes.
    localparam logic [1:0] DIR_OFF = 2'd0;
    localparam logic [1:0] DIR_FWD = 2'd1;
    localparam logic [1:0] DIR_REV = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_PWM_MAX       = 3'd0;
    localparam logic [2:0] REG_MIN_FWD_LEFT  = 3'd1;
    localparam logic [2:0] REG_MIN_REV_LEFT  = 3'd2;
    localparam logic [2:0] REG_MIN_FWD_RIGHT = 3'd3;
    localparam logic [2:0] REG_MIN_REV_RIGHT = 3'd4;
    localparam logic [2:0] REG_ACCEL_STEP    = 3'd5;
    localparam logic [2:0] REG_BRAKE_STEP    = 3'd6;
    localparam logic [2:0] REG_RAMP_PERIOD   = 3'd7;

    typedef struct packed {
        logic [7:0]  pwm_max;
        logic [7:0]  min_fwd_left;
        logic [7:0]  min_rev_left;
        logic [7:0]  min_fwd_right;
        logic [7:0]  min_rev_right;
        logic [7:0]  accel_step;
        logic [7:0]  brake_step;
        logic [15:0] ramp_period;
    } cfg_t;

    // Per-motor update strobes, already qualified by the pipeline advance.
    typedef struct packed {
        logic set_goal;
        logic stop;
        logic ramp;
    } motor_ctl_t;

    // Effective drive limit: pwm_max capped at the duty ceiling.
    function automatic logic [7:0] limit_of(input logic [7:0] pwm_max);
        logic [7:0] lim;
        if (int'(pwm_max) < DUTY_CEIL)
            lim = pwm_max;
        else
            lim = 8'(DUTY_CEIL);
        return lim;
    endfunction

endpackage

// File: rtl/dual_motor_ramp_pwm_drive.sv
// Two-channel H-bridge drive with slew limiting. Each command word is taken
// into an input register and then applied to the ramp state in a single pass
// of shallow add, compare and clamp logic; the ramp state itself is the result
// register, so res_valid rises at the edge that applies the word and the
// result reflects the state after that word. One word is taken every cycle as
// long as res_stall is low; while a result waits, one more word may sit in the
// input register.
// A set command stores both targets clamped to pwm_max; a tick counts one
// millisecond and, once ramp_period ticks have gathered, moves each speed
// toward its target by accel_step or brake_step and refreshes the applied
// drive (start minimum from rest, then clamp). An emergency stop clears
// targets, speeds, drives and the tick counter. Write configuration only
// while the block is idle.
module dual_motor_ramp_pwm_drive (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,

    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  logic [1:0]          cmd,
    input  logic signed [15:0]  left_target,
    input  logic signed [15:0]  right_target,

    output logic                res_valid,
    input  logic                res_stall,
    output logic [7:0]          left_duty,
    output logic [1:0]          left_dir,
    output logic [7:0]          right_duty,
    output logic [1:0]          right_dir,
    output logic signed [8:0]   left_speed,
    output logic signed [8:0]   right_speed,
    output logic                stopped
);

    dmr_pkg::cfg_t          cfg;
    dmr_pkg::motor_ctl_t    ctl;

    logic                   s1_full_reg, s1_full_next;
    logic [1:0]             s1_cmd_reg;
    logic signed [15:0]     s1_left_reg;
    logic signed [15:0]     s1_right_reg;
    logic                   res_valid_reg, res_valid_next;
    logic [15:0]            tick_count_reg, tick_count_next;
    logic [15:0]            tick_inc;
    logic                   blocked;
    logic                   advance;
    logic                   take;
    logic                   ramp_due;
    logic [7:0]             limit;

    dmr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // A finished word blocks the input register only while it is stalled.
    assign blocked   = res_valid_reg && res_stall;
    assign advance   = s1_full_reg && !blocked;
    assign cmd_stall = s1_full_reg && blocked;
    assign take      = cmd_valid && !cmd_stall;

    // Saturating tick count; the ramp fires once the count reaches the period.
    assign tick_inc = (tick_count_reg != 16'hFFFF) ? tick_count_reg + 16'd1 : tick_count_reg;
    assign ramp_due = (s1_cmd_reg == dmr_pkg::CMD_TICK) && (tick_inc >= cfg.ramp_period);
    assign limit    = dmr_pkg::limit_of(cfg.pwm_max);

    always_comb
    begin
        ctl.set_goal = advance && (s1_cmd_reg == dmr_pkg::CMD_SET);
        ctl.stop     = advance && (s1_cmd_reg == dmr_pkg::CMD_STOP);
        ctl.ramp     = advance && ramp_due;

        tick_count_next = tick_count_reg;
        if (advance)
        begin
            case (s1_cmd_reg)
                dmr_pkg::CMD_TICK: tick_count_next = ramp_due ? 16'd0 : tick_inc;
                dmr_pkg::CMD_STOP: tick_count_next = 16'd0;
                default:           tick_count_next = tick_count_reg;
            endcase
        end

        // Hold the input register while blocked, else refill or drain it.
        s1_full_next   = take || (s1_full_reg && blocked);
        // Raise the result flag when a word is applied, drop it once taken.
        res_valid_next = advance || blocked;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_full_reg    <= 1'b0;
            res_valid_reg  <= 1'b0;
            tick_count_reg <= '0;
        end
        else
        begin
            s1_full_reg    <= s1_full_next;
            res_valid_reg  <= res_valid_next;
            tick_count_reg <= tick_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_cmd_reg   <= cmd;
            s1_left_reg  <= left_target;
            s1_right_reg <= right_target;
        end
    end

    dmr_motor u_left (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .target     (s1_left_reg),
        .limit      (limit),
        .accel_step (cfg.accel_step),
        .brake_step (cfg.brake_step),
        .min_fwd    (cfg.min_fwd_left),
        .min_rev    (cfg.min_rev_left),
        .speed      (left_speed),
        .duty       (left_duty),
        .dir        (left_dir)
    );

    dmr_motor u_right (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .target     (s1_right_reg),
        .limit      (limit),
        .accel_step (cfg.accel_step),
        .brake_step (cfg.brake_step),
        .min_fwd    (cfg.min_fwd_right),
        .min_rev    (cfg.min_rev_right),
        .speed      (right_speed),
        .duty       (right_duty),
        .dir        (right_dir)
    );

    assign res_valid = res_valid_reg;
    assign stopped   = (left_speed == 9'sd0) && (right_speed == 9'sd0);

    // State must not move while a finished word is still waiting.
    a_hold_while_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        blocked |=> $stable(left_speed) && $stable(right_speed) && $stable(tick_count_reg))
        else $error("ramp state moved while result stalled");

    // An applied stop leaves both motors at rest with the bridges off.
    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.stop |=> stopped && left_dir == dmr_pkg::DIR_OFF && right_dir == dmr_pkg::DIR_OFF)
        else $error("emergency stop did not clear the drive");

    // Zero duty and the off code go together on the left channel.
    a_duty_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (left_duty == 8'd0) == (left_dir == dmr_pkg::DIR_OFF))
        else $error("left duty and direction disagree");

    // Stall is only raised with a word parked in the input register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> s1_full_reg && res_valid_reg)
        else $error("stall raised with nothing parked");

    // Every applied word yields a result in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid)
        else $error("applied word produced no result");

endmodule

// File: rtl/dmr_cfg_regs.sv
module dmr_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [15:0]     cfg_data,
    output dmr_pkg::cfg_t   cfg
);

    dmr_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pwm_max       <= 8'd255;
            cfg_reg.min_fwd_left  <= 8'd0;
            cfg_reg.min_rev_left  <= 8'd0;
            cfg_reg.min_fwd_right <= 8'd0;
            cfg_reg.min_rev_right <= 8'd0;
            cfg_reg.accel_step    <= 8'd5;
            cfg_reg.brake_step    <= 8'd5;
            cfg_reg.ramp_period   <= 16'd20;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dmr_pkg::REG_PWM_MAX:       cfg_reg.pwm_max       <= cfg_data[7:0];
                dmr_pkg::REG_MIN_FWD_LEFT:  cfg_reg.min_fwd_left  <= cfg_data[7:0];
                dmr_pkg::REG_MIN_REV_LEFT:  cfg_reg.min_rev_left  <= cfg_data[7:0];
                dmr_pkg::REG_MIN_FWD_RIGHT: cfg_reg.min_fwd_right <= cfg_data[7:0];
                dmr_pkg::REG_MIN_REV_RIGHT: cfg_reg.min_rev_right <= cfg_data[7:0];
                dmr_pkg::REG_ACCEL_STEP:    cfg_reg.accel_step    <= cfg_data[7:0];
                dmr_pkg::REG_BRAKE_STEP:    cfg_reg.brake_step    <= cfg_data[7:0];
                dmr_pkg::REG_RAMP_PERIOD:   cfg_reg.ramp_period   <= cfg_data;
                default:                    cfg_reg.ramp_period   <= cfg_reg.ramp_period;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/dmr_motor.sv
module dmr_motor (
    input  logic                    clk,
    input  logic                    rst_n,
    input  dmr_pkg::motor_ctl_t     ctl,
    input  logic signed [15:0]      target,
    input  logic [7:0]              limit,
    input  logic [7:0]              accel_step,
    input  logic [7:0]              brake_step,
    input  logic [7:0]              min_fwd,
    input  logic [7:0]              min_rev,
    output logic signed [8:0]       speed,
    output logic [7:0]              duty,
    output logic [1:0]              dir
);

    logic signed [8:0]  goal_reg, goal_next;
    logic signed [8:0]  now_reg, now_next;
    logic signed [8:0]  drive_reg, drive_next;

    logic signed [15:0] lim16;
    logic signed [10:0] now11, goal11, up11, down11;
    logic signed [8:0]  ramped;
    logic signed [9:0]  d10, lim10, mf10, mr10, raised, clamped;
    logic signed [8:0]  mag;

    // Clamp a fresh target to the drive limit.
    always_comb
    begin
        lim16 = signed'({8'd0, limit});
        if (target > lim16)
            goal_next = signed'({1'b0, limit});
        else if (target < -lim16)
            goal_next = -signed'({1'b0, limit});
        else
            goal_next = target[8:0];
    end

    // Move toward the goal by one step, never past it.
    always_comb
    begin
        now11  = 11'(now_reg);
        goal11 = 11'(goal_reg);
        up11   = now11 + signed'({3'd0, accel_step});
        down11 = now11 - signed'({3'd0, brake_step});
        if (now11 < goal11)
            ramped = (up11 > goal11) ? goal_reg : up11[8:0];
        else if (now11 > goal11)
            ramped = (down11 < goal11) ? goal_reg : down11[8:0];
        else
            ramped = now_reg;
    end

    // Raise to the start minimum when leaving rest, then clamp to the limit.
    always_comb
    begin
        d10    = 10'(ramped);
        lim10  = signed'({2'd0, limit});
        mf10   = signed'({2'd0, min_fwd});
        mr10   = signed'({2'd0, min_rev});
        raised = d10;
        if (d10 != 10'sd0 && now_reg == 9'sd0)
        begin
            if (d10 > 10'sd0 && d10 < mf10)
                raised = mf10;
            if (d10 < 10'sd0 && -d10 < mr10)
                raised = -mr10;
        end
        if (raised > lim10)
            clamped = lim10;
        else if (raised < -lim10)
            clamped = -lim10;
        else
            clamped = raised;
    end

    assign now_next   = ramped;
    assign drive_next = clamped[8:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_reg  <= '0;
            now_reg   <= '0;
            drive_reg <= '0;
        end
        else if (ctl.stop)
        begin
            goal_reg  <= '0;
            now_reg   <= '0;
            drive_reg <= '0;
        end
        else
        begin
            if (ctl.set_goal)
                goal_reg <= goal_next;
            if (ctl.ramp)
            begin
                now_reg   <= now_next;
                drive_reg <= drive_next;
            end
        end
    end

    assign mag   = drive_reg[8] ? -drive_reg : drive_reg;
    assign duty  = mag[7:0];
    assign dir   = (drive_reg == 9'sd0) ? dmr_pkg::DIR_OFF :
                   (drive_reg[8] ? dmr_pkg::DIR_REV : dmr_pkg::DIR_FWD);
    assign speed = now_reg;

endmodule

// File: sim/tb_dual_motor_ramp_pwm_drive.sv
module tb_dual_motor_ramp_pwm_drive;
    timeunit 1ns;
    timeprecision 1ps;

    // The package names three commands; the fourth code must be taken and ignored.
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_WORDS = 600;
    localparam int SUB_PHASES = 6;

    // One result word as the block presents it.
    typedef struct packed {
        logic [7:0]        left_duty;
        logic [1:0]        left_dir;
        logic [7:0]        right_duty;
        logic [1:0]        right_dir;
        logic signed [8:0] left_speed;
        logic signed [8:0] right_speed;
        logic              stopped;
    } drive_word_t;

    // One line of the directed plan: a register write or a command word, the latter
    // optionally with its result written out by hand.
    typedef struct {
        bit                 is_reg;
        logic [2:0]         idx;
        logic [15:0]        val;
        logic [1:0]         op;
        logic signed [15:0] lt;
        logic signed [15:0] rt;
        bit                 typed;
        drive_word_t        want;
    } plan_row_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [2:0]          cfg_index;
    logic [15:0]         cfg_data;
    logic                cmd_valid;
    logic                cmd_stall;
    logic [1:0]          cmd;
    logic signed [15:0]  left_target;
    logic signed [15:0]  right_target;
    logic                res_valid;
    logic                res_stall;
    logic [7:0]          left_duty;
    logic [1:0]          left_dir;
    logic [7:0]          right_duty;
    logic [1:0]          right_dir;
    logic signed [8:0]   left_speed;
    logic signed [8:0]   right_speed;
    logic                stopped;

    dual_motor_ramp_pwm_drive dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .left_target  (left_target),
        .right_target (right_target),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .left_duty    (left_duty),
        .left_dir     (left_dir),
        .right_duty   (right_duty),
        .right_dir    (right_dir),
        .left_speed   (left_speed),
        .right_speed  (right_speed),
        .stopped      (stopped)
    );

    // Shadow of the drive: registers, targets, ramped speeds, applied drives and the
    // millisecond count since the last ramp update.
    dmr_pkg::cfg_t     shadow;
    logic signed [8:0] goal_l, goal_r;
    logic signed [8:0] speed_l, speed_r;
    logic signed [8:0] drv_l, drv_r;
    logic [15:0]       ms_count;

    drive_word_t pending_drive [$];
    plan_row_t   plan [$];

    int faults = 0;
    int cycle_count = 0;
    int gap_pct = 0;
    int stall_pct = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up well beyond the slowest legal run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("dual_motor_ramp_pwm_drive: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drive model
    // ------------------------------------------------------------------

    // Drive limit: pwm_max, never above what the duty counter can express.
    function automatic int drive_limit();
        int lim;
        lim = int'(shadow.pwm_max);
        if (lim > dmr_pkg::DUTY_CEIL)
            lim = dmr_pkg::DUTY_CEIL;
        return lim;
    endfunction

    function automatic int clamp_limit(int v);
        int lim;
        lim = drive_limit();
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // Move one speed toward its target, never overshooting.
    function automatic int slew(int spd, int goal);
        int nxt;
        nxt = spd;
        if (spd < goal)
        begin
            nxt = spd + int'(shadow.accel_step);
            if (nxt > goal)
                nxt = goal;
        end
        else if (spd > goal)
        begin
            nxt = spd - int'(shadow.brake_step);
            if (nxt < goal)
                nxt = goal;
        end
        return nxt;
    endfunction

    // Applied drive: lift to the start minimum only when leaving rest, then clamp.
    function automatic int drive_for(int spd, int prev, int min_fwd, int min_rev);
        int d;
        d = spd;
        if (d != 0 && prev == 0)
        begin
            if (d > 0 && d < min_fwd)
                d = min_fwd;
            if (d < 0 && -d < min_rev)
                d = -min_rev;
        end
        return clamp_limit(d);
    endfunction

    function automatic logic [7:0] duty_of(int d);
        return (d < 0) ? 8'(-d) : 8'(d);
    endfunction

    function automatic logic [1:0] dir_of(int d);
        if (d > 0)
            return dmr_pkg::DIR_FWD;
        if (d < 0)
            return dmr_pkg::DIR_REV;
        return dmr_pkg::DIR_OFF;
    endfunction

    // Advance the shadow by one command word and form the word it reports.
    task automatic step_drive(input logic [1:0] op, input logic signed [15:0] lt,
                              input logic signed [15:0] rt, output drive_word_t w);
        int prev_l, prev_r;
        case (op)
            dmr_pkg::CMD_SET:
            begin
                goal_l = 9'(clamp_limit(int'(lt)));
                goal_r = 9'(clamp_limit(int'(rt)));
            end
            dmr_pkg::CMD_STOP:
            begin
                goal_l = '0;
                goal_r = '0;
                speed_l = '0;
                speed_r = '0;
                drv_l = '0;
                drv_r = '0;
                ms_count = '0;
            end
            dmr_pkg::CMD_TICK:
            begin
                if (ms_count != 16'hFFFF)
                    ms_count = ms_count + 16'd1;
                if (ms_count >= shadow.ramp_period)
                begin
                    prev_l = int'(speed_l);
                    prev_r = int'(speed_r);
                    ms_count = '0;
                    speed_l = 9'(slew(int'(speed_l), int'(goal_l)));
                    speed_r = 9'(slew(int'(speed_r), int'(goal_r)));
                    drv_l = 9'(drive_for(int'(speed_l), prev_l,
                                         int'(shadow.min_fwd_left), int'(shadow.min_rev_left)));
                    drv_r = 9'(drive_for(int'(speed_r), prev_r,
                                         int'(shadow.min_fwd_right), int'(shadow.min_rev_right)));
                end
            end
            default: ;
        endcase
        w.left_duty   = duty_of(int'(drv_l));
        w.left_dir    = dir_of(int'(drv_l));
        w.right_duty  = duty_of(int'(drv_r));
        w.right_dir   = dir_of(int'(drv_r));
        w.left_speed  = speed_l;
        w.right_speed = speed_r;
        w.stopped     = (speed_l == 0 && speed_r == 0);
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Write one register once every word in flight has come back. The shadow takes
    // the same value, masked to the width of the register.
    task automatic put_reg(input logic [2:0] idx, input logic [15:0] val);
        cmd_valid <= 1'b0;
        while (pending_drive.size() != 0)
            @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            dmr_pkg::REG_PWM_MAX:       shadow.pwm_max       = val[7:0];
            dmr_pkg::REG_MIN_FWD_LEFT:  shadow.min_fwd_left  = val[7:0];
            dmr_pkg::REG_MIN_REV_LEFT:  shadow.min_rev_left  = val[7:0];
            dmr_pkg::REG_MIN_FWD_RIGHT: shadow.min_fwd_right = val[7:0];
            dmr_pkg::REG_MIN_REV_RIGHT: shadow.min_rev_right = val[7:0];
            dmr_pkg::REG_ACCEL_STEP:    shadow.accel_step    = val[7:0];
            dmr_pkg::REG_BRAKE_STEP:    shadow.brake_step    = val[7:0];
            default:                    shadow.ramp_period   = val;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Offer one command word, hold it until taken, then log what should come back.
    // Entered and left at a falling edge; valid stays high for a following word.
    task automatic send_word(input logic [1:0] op, input logic signed [15:0] lt,
                             input logic signed [15:0] rt, input bit typed,
                             input drive_word_t want);
        drive_word_t model_w;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid    <= 1'b1;
        cmd          <= op;
        left_target  <= lt;
        right_target <= rt;
        do
            @(posedge clk);
        while (cmd_stall);
        step_drive(op, lt, rt, model_w);
        pending_drive.push_back(typed ? want : model_w);
        @(negedge clk);
    endtask

    // Targets: mostly inside the drive range, some raw 16-bit values, some edges.
    function automatic logic signed [15:0] pick_target();
        case ($urandom_range(0, 5))
            0, 1:    return 16'($urandom);
            2:
            begin
                case ($urandom_range(0, 5))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return 16'sd0;
                    3:       return 16'sd255;
                    4:       return -16'sd255;
                    default: return 16'(int'(shadow.pwm_max) + 1);
                endcase
            end
            default: return 16'(int'($urandom_range(0, 510)) - 255);
        endcase
    endfunction

    task automatic send_random_word();
        logic [1:0] op;
        int         r;
        r = $urandom_range(0, 99);
        if (r < 58)
            op = dmr_pkg::CMD_TICK;
        else if (r < 86)
            op = dmr_pkg::CMD_SET;
        else if (r < 93)
            op = dmr_pkg::CMD_STOP;
        else
            op = CMD_NONE;
        send_word(op, pick_target(), pick_target(), 1'b0, '0);
    endtask

    // Fresh settings for a sub-phase; upper data bits of byte registers carry junk.
    task automatic setup_phase();
        int r;
        r = $urandom_range(0, 9);
        put_reg(dmr_pkg::REG_PWM_MAX, {8'($urandom), (r == 0) ? 8'd0 : (r < 5) ? 8'd255 :
                                                     8'($urandom_range(1, 254))});
        put_reg(dmr_pkg::REG_MIN_FWD_LEFT,
                {8'($urandom), 8'($urandom_range(0, 3) == 0 ? 0 : $urandom)});
        put_reg(dmr_pkg::REG_MIN_REV_LEFT,
                {8'($urandom), 8'($urandom_range(0, 3) == 0 ? 0 : $urandom)});
        put_reg(dmr_pkg::REG_MIN_FWD_RIGHT,
                {8'($urandom), 8'($urandom_range(0, 3) == 0 ? 0 : $urandom)});
        put_reg(dmr_pkg::REG_MIN_REV_RIGHT,
                {8'($urandom), 8'($urandom_range(0, 3) == 0 ? 0 : $urandom)});
        r = $urandom_range(0, 9);
        put_reg(dmr_pkg::REG_ACCEL_STEP, {8'($urandom), (r == 0) ? 8'd0 : (r == 1) ? 8'd255 :
                                                        8'($urandom_range(1, 60))});
        r = $urandom_range(0, 9);
        put_reg(dmr_pkg::REG_BRAKE_STEP, {8'($urandom), (r == 0) ? 8'd0 : (r == 1) ? 8'd255 :
                                                        8'($urandom_range(1, 60))});
        put_reg(dmr_pkg::REG_RAMP_PERIOD, 16'($urandom_range(0, 3)));
    endtask

    function automatic drive_word_t word_of(int ld, logic [1:0] ldir, int rd,
                                            logic [1:0] rdir, int ls, int rs, bit st);
        drive_word_t w;
        w.left_duty   = 8'(ld);
        w.left_dir    = ldir;
        w.right_duty  = 8'(rd);
        w.right_dir   = rdir;
        w.left_speed  = 9'(ls);
        w.right_speed = 9'(rs);
        w.stopped     = st;
        return w;
    endfunction

    function automatic plan_row_t reg_row(logic [2:0] idx, logic [15:0] val);
        plan_row_t row;
        row = '{default: '0};
        row.is_reg = 1'b1;
        row.idx    = idx;
        row.val    = val;
        return row;
    endfunction

    function automatic plan_row_t cmd_row(logic [1:0] op, int lt, int rt, bit typed,
                                          drive_word_t want);
        plan_row_t row;
        row = '{default: '0};
        row.op    = op;
        row.lt    = 16'(lt);
        row.rt    = 16'(rt);
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    // Directed plan. Ramp period 1 makes every tick a ramp update, so each step
    // of the slew, the clamp and the start minimum shows at once.
    task automatic build_plan();
        drive_word_t at_rest;
        at_rest = word_of(0, dmr_pkg::DIR_OFF, 0, dmr_pkg::DIR_OFF, 0, 0, 1'b1);
        plan.push_back(cmd_row(dmr_pkg::CMD_TICK, 0, 0, 1'b1, at_rest));
        // unused code: nothing moves
        plan.push_back(cmd_row(CMD_NONE, 32767, -32768, 1'b1, at_rest));
        // targets clamp to the full limit; drive waits for a ramp update
        plan.push_back(cmd_row(dmr_pkg::CMD_SET, 32767, -32768, 1'b1, at_rest));
        plan.push_back(reg_row(dmr_pkg::REG_RAMP_PERIOD, 16'd1));
        plan.push_back(cmd_row(dmr_pkg::CMD_TICK, 0, 0, 1'b1,
                               word_of(5, dmr_pkg::DIR_FWD, 5, dmr_pkg::DIR_REV,
                                       5, -5, 1'b0)));
        plan.push_back(reg_row(dmr_pkg::REG_ACCEL_STEP, 16'd255));
        plan.push_back(reg_row(dmr_pkg::REG_BRAKE_STEP, 16'd255));
        // large steps stop exactly on the target
        plan.push_back(cmd_row(dmr_pkg::CMD_TICK, 0, 0, 1'b1,
                               word_of(255, dmr_pkg::DIR_FWD, 255, dmr_pkg::DIR_REV,
                                       255, -255, 1'b0)));
        // limit of zero: drive collapses, speeds stay, targets are not reclamped
        plan.push_back(reg_row(dmr_pkg::REG_PWM_MAX, 16'd0));
        plan.push_back(cmd_row(dmr_pkg::CMD_TICK, 0, 0, 1'b1,
                               word_of(0, dmr_pkg::DIR_OFF, 0, dmr_pkg::DIR_OFF,
                                       255, -255, 1'b0)));
        plan.push_back(cmd_row(dmr_pkg::CMD_SET, 100, -100, 1'b1,
                               word_of(0, dmr_pkg::DIR_OFF, 0, dmr_pkg::DIR_OFF,
                                       255, -255, 1'b0)));
        plan.push_back(cmd_row(dmr_pkg::CMD_TICK, 0, 0, 1'b1, at_rest));
        plan.push_back(reg_row(dmr_pkg::REG_PWM_MAX, 16'd255));
        plan.push_back(reg_row(dmr_pkg::REG_MIN_FWD_LEFT, 16'd200));
        plan.push_back(reg_row(dmr_pkg::REG_MIN_REV_LEFT, 16'd150));
        plan.push_back(reg_row(dmr_pkg::REG_MIN_FWD_RIGHT, 16'd7));
        plan.push_back(reg_row(dmr_pkg::REG_MIN_REV_RIGHT, 16'd255));
        plan.push_back(reg_row(dmr_pkg::REG_ACCEL_STEP, 16'd3));
        plan.push_back(reg_row(dmr_pkg::REG_BRAKE_STEP, 16'd3));
        plan.push_back(cmd_row(dmr_pkg::CMD_SET, 50, -50, 1'b1, at_rest));
        // leaving rest lifts the drive to the per-direction minimum
        plan.push_back(cmd_row(dmr_pkg::CMD_TICK, 0, 0, 1'b1,
                               word_of(200, dmr_pkg::DIR_FWD, 255, dmr_pkg::DIR_REV,
                                       3, -3, 1'b0)));
        // already moving: no lift
        plan.push_back(cmd_row(dmr_pkg::CMD_TICK, 0, 0, 1'b1,
                               word_of(6, dmr_pkg::DIR_FWD, 6, dmr_pkg::DIR_REV,
                                       6, -6, 1'b0)));
        plan.push_back(cmd_row(dmr_pkg::CMD_STOP, 0, 0, 1'b1, at_rest));
        plan.push_back(cmd_row(dmr_pkg::CMD_SET, -50, 50, 1'b1, at_rest));
        plan.push_back(cmd_row(dmr_pkg::CMD_TICK, 0, 0, 1'b1,
                               word_of(150, dmr_pkg::DIR_REV, 7, dmr_pkg::DIR_FWD,
                                       -3, 3, 1'b0)));
        // period zero ramps on every tick; a zero step freezes that direction
        plan.push_back(reg_row(dmr_pkg::REG_RAMP_PERIOD, 16'd0));
        plan.push_back(reg_row(dmr_pkg::REG_ACCEL_STEP, 16'd0));
        plan.push_back(cmd_row(dmr_pkg::CMD_TICK, 0, 0, 1'b0, '0));
        plan.push_back(reg_row(dmr_pkg::REG_BRAKE_STEP, 16'd0));
        plan.push_back(cmd_row(dmr_pkg::CMD_TICK, 0, 0, 1'b0, '0));
        plan.push_back(reg_row(dmr_pkg::REG_ACCEL_STEP, 16'd9));
        plan.push_back(reg_row(dmr_pkg::REG_RAMP_PERIOD, 16'hFFFF));
        plan.push_back(cmd_row(dmr_pkg::CMD_TICK, 0, 0, 1'b0, '0));
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            res_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    function automatic bit field_ok(string name, logic signed [15:0] want,
                                    logic signed [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Compare every word taken against the oldest one logged.
    always @(posedge clk)
    begin
        drive_word_t want;
        bit          ok;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_drive.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, got %h", $time,
                         {left_duty, left_dir, right_duty, right_dir, left_speed,
                          right_speed, stopped});
                faults++;
            end
            else
            begin
                want = pending_drive.pop_front();
                ok = 1'b1;
                ok &= field_ok("left_duty", 16'(want.left_duty), 16'(left_duty));
                ok &= field_ok("left_dir", 16'(want.left_dir), 16'(left_dir));
                ok &= field_ok("right_duty", 16'(want.right_duty), 16'(right_duty));
                ok &= field_ok("right_dir", 16'(want.right_dir), 16'(right_dir));
                ok &= field_ok("left_speed", 16'(want.left_speed), 16'(left_speed));
                ok &= field_ok("right_speed", 16'(want.right_speed), 16'(right_speed));
                ok &= field_ok("stopped", 16'(want.stopped), 16'(stopped));
                if (!ok)
                    faults++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = dmr_pkg::REG_PWM_MAX;
        cfg_data     = '0;
        cmd_valid    = 1'b0;
        cmd          = dmr_pkg::CMD_TICK;
        left_target  = '0;
        right_target = '0;

        // shadow starts from the reset values of the registers
        shadow.pwm_max       = 8'd255;
        shadow.min_fwd_left  = 8'd0;
        shadow.min_rev_left  = 8'd0;
        shadow.min_fwd_right = 8'd0;
        shadow.min_rev_right = 8'd0;
        shadow.accel_step    = 8'd5;
        shadow.brake_step    = 8'd5;
        shadow.ramp_period   = 16'd20;
        goal_l   = '0;
        goal_r   = '0;
        speed_l  = '0;
        speed_r  = '0;
        drv_l    = '0;
        drv_r    = '0;
        ms_count = '0;

        build_plan();

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Directed plan under the first idling mix.
        gap_pct   = 38;
        stall_pct = 51;
        foreach (plan[i])
        begin
            if (plan[i].is_reg)
                put_reg(plan[i].idx, plan[i].val);
            else
                send_word(plan[i].op, plan[i].lt, plan[i].rt, plan[i].typed, plan[i].want);
        end

        // Random words: two sub-phases per idling mix, each with its own settings.
        for (int p = 0; p < SUB_PHASES; p++)
        begin
            case (p / 2)
                0:
                begin
                    gap_pct   = 38;
                    stall_pct = 51;
                end
                1:
                begin
                    gap_pct   = 51;
                    stall_pct = 38;
                end
                default:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
            endcase
            setup_phase();
            repeat (RANDOM_WORDS / SUB_PHASES)
                send_random_word();
        end

        // Drop valid, let everything drain, then allow for stray words.
        cmd_valid <= 1'b0;
        while (pending_drive.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);

        if (faults == 0)
            $display("dual_motor_ramp_pwm_drive: match");
        else
            $display("dual_motor_ramp_pwm_drive: mismatch");
        $finish;
    end

endmodule

// File: files.f
rtl/dmr_pkg.sv
rtl/dmr_cfg_regs.sv
rtl/dmr_motor.sv
rtl/dual_motor_ramp_pwm_drive.sv
sim/tb_dual_motor_ramp_pwm_drive.sv
